### hw/rtl/utf8_text_validator_defines.svh
// ---------------------------------------------------------------------------
// utf8_text_validator_defines.svh
// Assertion macros for the UTF-8 text validator; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef UTF8_TEXT_VALIDATOR_DEFINES_SVH
`define UTF8_TEXT_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define UTF8V_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define UTF8V_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UTF8V_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define UTF8V_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/utf8v_pkg.sv
// ---------------------------------------------------------------------------
// utf8v_pkg
// Types and constants shared by the UTF-8 text validator modules.
// ---------------------------------------------------------------------------
package utf8v_pkg;

    localparam int BYTE_W  = 8;
    localparam int MAX_W   = 10;
    localparam int COUNT_W = 11;
    localparam int CP_W    = 21;

    localparam logic [MAX_W-1:0]   MAX_BYTES_RESET = 10'd255;
    localparam logic [COUNT_W-1:0] COUNT_TOP       = 11'd2047;

    // Sequence lengths
    localparam logic [2:0] LEN_1 = 3'd1;
    localparam logic [2:0] LEN_2 = 3'd2;
    localparam logic [2:0] LEN_3 = 3'd3;
    localparam logic [2:0] LEN_4 = 3'd4;

    // Lead and continuation byte patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    // Code point limits
    localparam logic [CP_W-1:0] CP_MIN_LEN2  = 21'h00080;
    localparam logic [CP_W-1:0] CP_MIN_LEN3  = 21'h00800;
    localparam logic [CP_W-1:0] CP_MIN_LEN4  = 21'h10000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h0D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h0DFFF;
    localparam logic [CP_W-1:0] CP_CTRL_LIM  = 21'h00020;
    localparam logic [CP_W-1:0] CP_DEL       = 21'h0007F;

    typedef struct packed {
        logic [1:0]         remaining;
        logic [2:0]         seq_len;
        logic [CP_W-1:0]    code_point;
        logic               err;
        logic [COUNT_W-1:0] count;
    } text_state_t;

endpackage

### hw/rtl/utf8v_step.sv
// ---------------------------------------------------------------------------
// utf8v_step
// Next text state after one byte: decode, continuation and code point checks.
// ---------------------------------------------------------------------------
module utf8v_step (
    input  utf8v_pkg::text_state_t        cur,
    input  logic [utf8v_pkg::BYTE_W-1:0]  data,
    output utf8v_pkg::text_state_t        nxt
);

    logic [utf8v_pkg::CP_W-1:0] shifted;
    logic [1:0]                 rem_dec;

    function automatic logic cp_bad(input logic [utf8v_pkg::CP_W-1:0] cp,
                                    input logic [2:0] len);
        logic overlong;
        overlong = (len == utf8v_pkg::LEN_2 && cp < utf8v_pkg::CP_MIN_LEN2) ||
                   (len == utf8v_pkg::LEN_3 && cp < utf8v_pkg::CP_MIN_LEN3) ||
                   (len == utf8v_pkg::LEN_4 && cp < utf8v_pkg::CP_MIN_LEN4);
        return overlong || cp > utf8v_pkg::CP_MAX ||
               (cp >= utf8v_pkg::CP_SURR_LO && cp <= utf8v_pkg::CP_SURR_HI) ||
               cp < utf8v_pkg::CP_CTRL_LIM || cp == utf8v_pkg::CP_DEL;
    endfunction

    assign shifted = {cur.code_point[utf8v_pkg::CP_W-7:0], data[5:0]};
    assign rem_dec = cur.remaining - 2'd1;

    always_comb
    begin
        nxt = cur;
        if (cur.count != utf8v_pkg::COUNT_TOP)
        begin
            nxt.count = cur.count + 11'd1;
        end
        if (!cur.err)
        begin
            if (cur.remaining == 2'd0)
            begin
                if (!data[7])
                begin
                    if (cp_bad({13'd0, data}, utf8v_pkg::LEN_1))
                    begin
                        nxt.err = 1'b1;
                    end
                end
                else if ((data & utf8v_pkg::LEAD2_MASK) == utf8v_pkg::LEAD2_CODE)
                begin
                    nxt.code_point = {16'd0, data[4:0]};
                    nxt.seq_len    = utf8v_pkg::LEN_2;
                    nxt.remaining  = 2'd1;
                end
                else if ((data & utf8v_pkg::LEAD3_MASK) == utf8v_pkg::LEAD3_CODE)
                begin
                    nxt.code_point = {17'd0, data[3:0]};
                    nxt.seq_len    = utf8v_pkg::LEN_3;
                    nxt.remaining  = 2'd2;
                end
                else if ((data & utf8v_pkg::LEAD4_MASK) == utf8v_pkg::LEAD4_CODE)
                begin
                    nxt.code_point = {18'd0, data[2:0]};
                    nxt.seq_len    = utf8v_pkg::LEN_4;
                    nxt.remaining  = 2'd3;
                end
                else
                begin
                    nxt.err = 1'b1;
                end
            end
            else if ((data & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_CODE)
            begin
                nxt.err        = 1'b1;
                nxt.remaining  = 2'd0;
                nxt.seq_len    = 3'd0;
                nxt.code_point = '0;
            end
            else if (rem_dec != 2'd0)
            begin
                nxt.code_point = shifted;
                nxt.remaining  = rem_dec;
            end
            else
            begin
                // sequence complete: check, then drop decode state either way
                nxt.err        = cp_bad(shifted, cur.seq_len);
                nxt.remaining  = 2'd0;
                nxt.seq_len    = 3'd0;
                nxt.code_point = '0;
            end
        end
    end

endmodule

### hw/rtl/utf8_text_validator.sv
// ---------------------------------------------------------------------------
// utf8_text_validator
// Byte-stream UTF-8 checker giving one valid/invalid verdict per text.
// ---------------------------------------------------------------------------
// Path from input beat to result beat: input register, then result register.
// Throughput: one byte per cycle while in_ready is high; the per-byte decode is one stage of logic.
// in_ready drops only while a result is waiting and the staged byte closes a text.
// Reset: text state and both valid flags clear; max_bytes returns to 255.
`include "utf8_text_validator_defines.svh"

module utf8_text_validator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [utf8v_pkg::MAX_W-1:0]      cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [utf8v_pkg::BYTE_W-1:0]     text_byte,
    input  logic                             last_byte,
    input  logic                             empty_text,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             text_valid
);

    logic [utf8v_pkg::MAX_W-1:0]  max_bytes_reg;
    logic                         in_v_reg;
    logic [utf8v_pkg::BYTE_W-1:0] byte_reg;
    logic                         last_reg;
    logic                         empty_reg;
    utf8v_pkg::text_state_t       state_reg;
    utf8v_pkg::text_state_t       state_next;
    utf8v_pkg::text_state_t       stepped;
    utf8v_pkg::text_state_t       post;
    logic                         out_v_reg;
    logic                         out_v_next;
    logic                         text_valid_reg;
    logic                         closes;
    logic                         advance;
    logic                         ok;

    utf8v_step u_step (
        .cur  (state_reg),
        .data (byte_reg),
        .nxt  (stepped)
    );

    assign closes  = empty_reg || last_reg;
    assign advance = in_v_reg && (!closes || !out_v_reg || out_ready);
    assign in_ready = !in_v_reg || advance;

    // an empty beat judges the text as it stands, adding no byte
    assign post = empty_reg ? state_reg : stepped;
    assign ok   = !post.err && post.remaining == 2'd0 && post.count != '0 &&
                  post.count <= {1'b0, max_bytes_reg};

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            state_next = closes ? '0 : post;
        end
        out_v_next = out_v_reg;
        if (advance && closes)
        begin
            out_v_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= utf8v_pkg::MAX_BYTES_RESET;
            in_v_reg      <= 1'b0;
            state_reg     <= '0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_bytes_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                in_v_reg <= in_valid;
            end
            state_reg <= state_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= text_byte;
            last_reg  <= last_byte;
            empty_reg <= empty_text;
        end
        if (advance && closes)
        begin
            text_valid_reg <= ok;
        end
    end

    assign out_valid  = out_v_reg;
    assign text_valid = text_valid_reg;

    `UTF8V_ASSERT_NEXT(a_clear_after_close, clk, rst_n, advance && closes,
        state_reg.count == '0 && !state_reg.err && state_reg.remaining == 2'd0,
        "text state not cleared after verdict")
    `UTF8V_ASSERT_NEXT(a_count_after_byte, clk, rst_n, advance && !closes,
        state_reg.count != '0, "byte not counted")
    `UTF8V_ASSERT_NOW(a_seq_consistent, clk, rst_n, state_reg.remaining != 2'd0,
        3'(state_reg.remaining) < state_reg.seq_len &&
        state_reg.seq_len <= utf8v_pkg::LEN_4,
        "pending continuation count inconsistent with sequence length")
    `UTF8V_ASSERT_NOW(a_err_clears_decode, clk, rst_n, state_reg.err,
        state_reg.remaining == 2'd0 && state_reg.seq_len == 3'd0 &&
        state_reg.code_point == '0, "decode state left after error")
    `UTF8V_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready,
        in_v_reg && closes && out_v_reg && !out_ready, "input stalled without cause")

endmodule

### sim/utf8_text_validator_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_text_validator_test
// Self-checking bench for the UTF-8 text validator. Texts are fed a beat at a
// time: well-formed texts with random content, texts with one bad character
// (control, overlong, surrogate, out of range, stray or cut sequence), empty
// texts and long texts at and past the byte limit. A model inside the bench
// predicts one verdict per closed text, and every result beat is compared with
// the oldest prediction.
// ---------------------------------------------------------------------------
module utf8_text_validator_test;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum int {
        CH_ASCII, CH_TWO, CH_THREE, CH_FOUR,
        CH_CONTROL, CH_OVERLONG, CH_SURROGATE, CH_ABOVE_MAX,
        CH_STRAY_CONT, CH_BAD_LEAD, CH_CUT, CH_RAW
    } char_kind_t;

    typedef logic [utf8v_pkg::CP_W-1:0] cp_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_wr_en;
    logic [utf8v_pkg::MAX_W-1:0]       cfg_wr_data;
    logic                              in_valid;
    logic                              in_ready;
    logic [utf8v_pkg::BYTE_W-1:0]      text_byte;
    logic                              last_byte;
    logic                              empty_text;
    logic                              out_valid;
    logic                              out_ready;
    logic                              text_valid;

    // bench model of the text state
    logic [utf8v_pkg::MAX_W-1:0]       text_limit;
    logic [1:0]                        cont_pending;
    logic [2:0]                        seq_len_q;
    cp_t                               cp_acc;
    logic                              text_err;
    logic [utf8v_pkg::COUNT_W-1:0]     text_len;

    logic               expected_verdicts[$];
    logic [7:0]         text_buf[$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 hold_off_cycles = 0;
    bit                 quiet = 1'b0;

    utf8_text_validator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .last_byte   (last_byte),
        .empty_text  (empty_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .text_valid  (text_valid)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic bit code_point_rejected(input cp_t cp, input logic [2:0] len);
        bit overlong;
        overlong = (len == utf8v_pkg::LEN_2 && cp < utf8v_pkg::CP_MIN_LEN2) ||
                   (len == utf8v_pkg::LEN_3 && cp < utf8v_pkg::CP_MIN_LEN3) ||
                   (len == utf8v_pkg::LEN_4 && cp < utf8v_pkg::CP_MIN_LEN4);
        return overlong || cp > utf8v_pkg::CP_MAX ||
               (cp >= utf8v_pkg::CP_SURR_LO && cp <= utf8v_pkg::CP_SURR_HI) ||
               cp < utf8v_pkg::CP_CTRL_LIM || cp == utf8v_pkg::CP_DEL;
    endfunction

    task automatic flag_error();
        text_err     = 1'b1;
        cont_pending = '0;
        seq_len_q    = '0;
        cp_acc       = '0;
    endtask

    task automatic clear_text();
        cont_pending = '0;
        seq_len_q    = '0;
        cp_acc       = '0;
        text_err     = 1'b0;
        text_len     = '0;
    endtask

    // Advance the model by one accepted beat; a closed text yields one verdict.
    task automatic absorb_beat(input logic [7:0] b, input logic l, input logic e);
        if (!e)
        begin
            if (text_len != utf8v_pkg::COUNT_TOP)
                text_len++;
            // once a text has failed, bytes are only counted
            if (!text_err)
            begin
                if (cont_pending == 2'd0)
                begin
                    if (!b[7])
                    begin
                        if (code_point_rejected({13'd0, b}, utf8v_pkg::LEN_1))
                            flag_error();
                    end
                    else if ((b & utf8v_pkg::LEAD2_MASK) == utf8v_pkg::LEAD2_CODE)
                    begin
                        cp_acc = {16'd0, b[4:0]};
                        seq_len_q = utf8v_pkg::LEN_2;
                        cont_pending = 2'd1;
                    end
                    else if ((b & utf8v_pkg::LEAD3_MASK) == utf8v_pkg::LEAD3_CODE)
                    begin
                        cp_acc = {17'd0, b[3:0]};
                        seq_len_q = utf8v_pkg::LEN_3;
                        cont_pending = 2'd2;
                    end
                    else if ((b & utf8v_pkg::LEAD4_MASK) == utf8v_pkg::LEAD4_CODE)
                    begin
                        cp_acc = {18'd0, b[2:0]};
                        seq_len_q = utf8v_pkg::LEN_4;
                        cont_pending = 2'd3;
                    end
                    else
                        flag_error();
                end
                else if ((b & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_CODE)
                    flag_error();
                else
                begin
                    cp_acc = {cp_acc[utf8v_pkg::CP_W-7:0], b[5:0]};
                    cont_pending--;
                    if (cont_pending == 2'd0)
                    begin
                        if (code_point_rejected(cp_acc, seq_len_q))
                            flag_error();
                        else
                        begin
                            seq_len_q = '0;
                            cp_acc = '0;
                        end
                    end
                end
            end
        end
        if (e || l)
        begin
            expected_verdicts.insert(expected_verdicts.size(),
                                     !text_err && cont_pending == 2'd0 &&
                                     text_len != '0 && text_len <= {1'b0, text_limit});
            clear_text();
        end
    endtask

    // Model update comes first so a result in the same cycle still finds its verdict.
    always @(posedge clk)
    begin
        logic want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                absorb_beat(text_byte, last_byte, empty_text);
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: text_valid expected none, actual %0b", $time, text_valid);
                    error_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (text_valid !== want)
                    begin
                        $display("%0t: text_valid expected %0b, actual %0b",
                                 $time, want, text_valid);
                        error_count++;
                    end
                end
            end
        end
    end

    // Result side: random stall per verdict, plus a long hold-off when asked.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            stall = quiet ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                do @(posedge clk); while (!out_valid);
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Called just after an edge; returns just after the edge that takes the beat.
    task automatic send_beat(input logic [7:0] b, input logic l, input logic e);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        text_byte  <= b;
        last_byte  <= l;
        empty_text <= e;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_text(input bit close_with_empty);
        foreach (text_buf[i])
            send_beat(text_buf[i], !close_with_empty && i == text_buf.size() - 1, 1'b0);
        if (close_with_empty)
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0) @(posedge clk);
        // two-stage pipe: let any trailing work settle
        repeat (4) @(posedge clk);
    endtask

    task automatic set_byte_limit(input logic [utf8v_pkg::MAX_W-1:0] limit);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        text_limit = limit;
    endtask

    task automatic add_byte(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endtask

    // Append one character of the given kind to text_buf, encoded as UTF-8.
    task automatic append_char(input char_kind_t kind);
        cp_t cp;
        int len;
        int cut;
        len = 1;
        cut = 0;
        case (kind)
            CH_ASCII:      cp = cp_t'($urandom_range(8'h20, 8'h7E));
            CH_TWO:
            begin
                cp = cp_t'($urandom_range(12'h080, 12'h7FF));
                len = 2;
            end
            CH_THREE:
            begin
                cp = cp_t'($urandom_range(16'h0800, 16'hFFFF));
                if (cp >= utf8v_pkg::CP_SURR_LO && cp <= utf8v_pkg::CP_SURR_HI)
                    cp = cp ^ 21'h08000;
                len = 3;
            end
            CH_FOUR:
            begin
                cp = cp_t'($urandom_range(21'h10000, 21'h10FFFF));
                len = 4;
            end
            CH_CONTROL:
                cp = $urandom_range(0, 1) ? utf8v_pkg::CP_DEL
                                          : cp_t'($urandom_range(0, 8'h1F));
            CH_OVERLONG:
            begin
                len = $urandom_range(2, 4);
                cp = cp_t'($urandom_range(0, len == 2 ? 16'h007F :
                                             len == 3 ? 16'h07FF : 16'hFFFF));
            end
            CH_SURROGATE:
            begin
                cp = cp_t'($urandom_range(utf8v_pkg::CP_SURR_LO, utf8v_pkg::CP_SURR_HI));
                len = 3;
            end
            CH_ABOVE_MAX:
            begin
                cp = cp_t'($urandom_range(21'h110000, 21'h1FFFFF));
                len = 4;
            end
            CH_STRAY_CONT: cp = cp_t'($urandom_range(8'h80, 8'hBF));
            CH_BAD_LEAD:   cp = cp_t'($urandom_range(8'hF8, 8'hFF));
            CH_CUT:
            begin
                len = $urandom_range(2, 4);
                cp = cp_t'($urandom_range(0, 21'h10FFFF));
                cut = $urandom_range(1, len - 1);
            end
            default:       cp = cp_t'($urandom_range(0, 255));
        endcase
        case (len)
            1: add_byte(cp[7:0]);
            2:
            begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
        repeat (cut) text_buf.delete(text_buf.size() - 1);
    endtask

    task automatic test_directed();
        text_buf = '{8'h41};                     send_text(1'b0);
        text_buf = '{8'h7F};                     send_text(1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);            // empty text
        text_buf = '{8'hC2, 8'h80};              send_text(1'b0);
        text_buf = '{8'hC1, 8'hBF};              send_text(1'b0);
        text_buf = '{8'hED, 8'hA0, 8'h80};       send_text(1'b0);
        text_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_text(1'b0);
        text_buf = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_text(1'b0);
        text_buf = '{8'h80};                     send_text(1'b0);
        text_buf = '{8'hC3};                     send_text(1'b0);
        // bytes closed by an empty beat instead of a last mark
        text_buf = '{8'h41};                     send_text(1'b1);
        // bytes after a failure are counted, not decoded
        text_buf = '{8'hC0, 8'h41, 8'h41};       send_text(1'b0);
    endtask

    task automatic test_byte_limit();
        set_byte_limit('0);
        text_buf = '{8'h41};                     send_text(1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        set_byte_limit(10'd1);
        text_buf = '{8'h41};                     send_text(1'b0);
        text_buf = '{8'h41, 8'h42};              send_text(1'b0);
        text_buf = '{8'hC2, 8'hA9};              send_text(1'b0);
    endtask

    // Long texts exactly at the limit and one byte past it.
    task automatic test_long_texts();
        int lengths[2] = '{200, 201};
        set_byte_limit(10'd200);
        quiet = 1'b1;
        foreach (lengths[k])
        begin
            text_buf.delete();
            repeat (lengths[k]) append_char(CH_ASCII);
            send_text(1'b0);
        end
        quiet = 1'b0;
        drain_results();
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        hold_off_cycles = 300;
        repeat (40)
        begin
            text_buf.delete();
            append_char(CH_ASCII);
            send_text(1'b0);
        end
        drain_results();
        quiet = 1'b0;
    endtask

    task automatic run_random_texts(input int beats);
        int sent;
        int nchars;
        int defect_at;
        int shape;
        sent = 0;
        while (sent < beats)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            shape = $urandom_range(0, 19);
            if (shape == 0)
            begin
                send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                sent++;
            end
            else
            begin
                nchars = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 70)
                                                       : $urandom_range(1, 8);
                defect_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, nchars - 1) : -1;
                text_buf.delete();
                for (int i = 0; i < nchars; i++)
                    append_char(i == defect_at ? char_kind_t'($urandom_range(CH_CONTROL, CH_RAW))
                                               : char_kind_t'($urandom_range(CH_ASCII, CH_FOUR)));
                sent += text_buf.size() + (shape == 1);
                send_text(shape == 1);
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_random();
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_byte_limit(utf8v_pkg::MAX_BYTES_RESET);
                1: set_byte_limit(10'd1023);
                2: set_byte_limit('0);
                3: set_byte_limit(10'd1);
                4: set_byte_limit(10'($urandom_range(2, 40)));
                default: set_byte_limit(10'($urandom_range(0, 1023)));
            endcase
            run_random_texts(110);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        text_byte   = '0;
        last_byte   = 1'b0;
        empty_text  = 1'b0;
        text_limit  = utf8v_pkg::MAX_BYTES_RESET;
        clear_text();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_byte_limit();
        test_long_texts();
        test_backpressure();
        test_random();

        drain_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/utf8v_pkg.sv
hw/rtl/utf8v_step.sv
hw/rtl/utf8_text_validator.sv
sim/utf8_text_validator_test.sv
